// ----- hw/rtl/ffea_pkg.sv -----
// Package for the first-fit extent allocator.
// Holds the payload widths and the operation, status and table codes.
// Depends on nothing; every other file of the block but ffea_table imports it.
package ffea_pkg;

    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_AT   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_FREE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTALLOC = 2'd2;
    localparam logic [STAT_W-1:0] ST_NODESC   = 2'd3;

    localparam logic TB_FREE  = 1'b0;
    localparam logic TB_ALLOC = 1'b1;

endpackage

// ----- hw/rtl/ffea_if.sv -----
// Handshake interfaces of the first-fit extent allocator.
// ffea_req_if carries request beats, ffea_rsp_if carries result beats.
// Depends on ffea_pkg.
interface ffea_req_if import ffea_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] size;
    logic              merge;

    modport source (output valid, func, addr, size, merge, input ready);
    modport sink   (input valid, func, addr, size, merge, output ready);
endinterface

interface ffea_rsp_if import ffea_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_addr;
    logic [STAT_W-1:0] status;

    modport source (output valid, result_addr, status, input ready);
    modport sink   (input valid, result_addr, status, output ready);
endinterface

// ----- hw/rtl/ffea_table.sv -----
// Extent table storage: a simple dual-port synchronous memory.
// One write port, one read port with registered data.
// Depends on nothing beyond its parameters.
module ffea_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/first_fit_extent_allocator.sv -----
// Channel | dir | beat contents
// --------+-----+-------------------------------------------
// req     | in  | func, addr, size, merge
// rsp     | out | result_addr, status
//
// A request scans one table, one entry a cycle, up to the entry it needs. It
// then shifts only the entries above that point. An operation that moves an
// extent into the other table then scans and shifts that table as well. Both
// tables share the ENTRIES descriptors, and each table memory has a single
// read port. Reset clears both counts and the control state. Table
// contents are not cleared, and only entries below a count are ever read.
// A result waits in an output register, so a new request is taken while
// rsp is stalled.
module first_fit_extent_allocator
    import ffea_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int ADDR_W  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ffea_req_if.sink   req,
    ffea_rsp_if.source rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int W  = ADDR_W;
    localparam int DW = 2 * ADDR_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_RM   = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_POST = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // The main phase serves the request itself; the add phase inserts the
    // extent that moves into the other table.
    localparam logic PH_MAIN = 1'b0;
    localparam logic PH_ADD  = 1'b1;

    logic [2:0]        state_reg, state_next;
    logic              phase_reg, phase_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic              tsel_reg, tsel_next;
    logic [W-1:0]      ka_reg, ka_next;
    logic [W-1:0]      ks_reg, ks_next;
    logic              km_reg, km_next;
    logic [CW-1:0]     ri_reg, ri_next;
    logic [CW-1:0]     rj_reg, rj_next;
    logic              pv_reg, pv_next;
    logic [W-1:0]      prev_s_reg, prev_s_next;
    logic [W-1:0]      prev_l_reg, prev_l_next;
    logic              wr_p_reg, wr_p_next;
    logic [AW-1:0]     wr_i_reg, wr_i_next;
    logic [DW-1:0]     wr_d_reg, wr_d_next;
    logic              rm_p_reg, rm_p_next;
    logic [AW-1:0]     rm_i_reg, rm_i_next;
    logic              ins_p_reg, ins_p_next;
    logic [AW-1:0]     ins_i_reg, ins_i_next;
    logic [DW-1:0]     ins_d_reg, ins_d_next;
    logic              go_add_reg, go_add_next;
    logic              add_t_reg, add_t_next;
    logic [W-1:0]      add_a_reg, add_a_next;
    logic [W-1:0]      add_s_reg, add_s_next;
    logic              add_m_reg, add_m_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [W-1:0]      res_reg, res_next;
    logic [CW-1:0]     fcnt_reg, fcnt_next;
    logic [CW-1:0]     acnt_reg, acnt_next;
    logic              out_v_reg, out_v_next;
    logic [STAT_W-1:0] out_st_reg, out_st_next;
    logic [W-1:0]      out_res_reg, out_res_next;

    // Memory port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] f_rdata, a_rdata, rd;

    // Datapath terms evaluated on the entry returned by the memory.
    logic [W-1:0]  rs, rl, rend, kend;
    logic [CW-1:0] n_sel, pos;
    logic [CW:0]   used;
    logic          spare0, spare1;
    logic          is_add, match, hit, done_nf;
    logic          r_jp, r_m2, r_split, k0, k1, k2, need_bad;
    logic          go_act;

    ffea_table #(.DEPTH(ENTRIES), .AW(AW), .DW(DW)) u_free_tbl (
        .clk   (clk),
        .we    (mem_we && (tsel_reg == TB_FREE)),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (f_rdata)
    );

    ffea_table #(.DEPTH(ENTRIES), .AW(AW), .DW(DW)) u_alloc_tbl (
        .clk   (clk),
        .we    (mem_we && (tsel_reg == TB_ALLOC)),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (a_rdata)
    );

    assign rd    = (tsel_reg == TB_ALLOC) ? a_rdata : f_rdata;
    assign rs    = rd[DW-1:W];
    assign rl    = rd[W-1:0];
    assign rend  = rs + rl;
    assign kend  = ka_reg + ks_reg;
    assign n_sel = (tsel_reg == TB_ALLOC) ? acnt_reg : fcnt_reg;
    assign used  = {1'b0, fcnt_reg} + {1'b0, acnt_reg};

    // No spare descriptor, and fewer than two.
    assign spare0 = used >= (CW+1)'(ENTRIES);
    assign spare1 = used >= (CW+1)'(ENTRIES - 1);

    assign is_add = (phase_reg == PH_ADD) || (func_reg == FN_ADD);

    always_comb
    begin
        if (is_add)
        begin
            match = ka_reg < rs;
        end
        else
        begin
            unique case (func_reg)
                FN_FIT:  match = rl >= ks_reg;
                FN_AT:   match = (rs <= ka_reg) && (kend <= rend);
                FN_FREE: match = rs == ka_reg;
                default: match = 1'b0;
            endcase
        end
    end

    assign hit     = pv_reg && match;
    assign done_nf = !pv_reg && (ri_reg >= n_sel);
    assign pos     = hit ? rj_reg : n_sel;

    // Joining with the predecessor, and with the successor.
    assign r_jp = km_reg && (pos != '0) && ((prev_s_reg + prev_l_reg) == ka_reg);
    assign r_m2 = km_reg && hit && (kend == rs);

    assign r_split  = ks_reg < rl;
    assign k0       = rl == ks_reg;
    assign k1       = rs == ka_reg;
    assign k2       = rend == kend;
    assign need_bad = k0 ? 1'b0 : ((k1 || k2) ? spare0 : spare1);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        func_next    = func_reg;
        tsel_next    = tsel_reg;
        ka_next      = ka_reg;
        ks_next      = ks_reg;
        km_next      = km_reg;
        ri_next      = ri_reg;
        rj_next      = rj_reg;
        pv_next      = pv_reg;
        prev_s_next  = prev_s_reg;
        prev_l_next  = prev_l_reg;
        wr_p_next    = wr_p_reg;
        wr_i_next    = wr_i_reg;
        wr_d_next    = wr_d_reg;
        rm_p_next    = rm_p_reg;
        rm_i_next    = rm_i_reg;
        ins_p_next   = ins_p_reg;
        ins_i_next   = ins_i_reg;
        ins_d_next   = ins_d_reg;
        go_add_next  = go_add_reg;
        add_t_next   = add_t_reg;
        add_a_next   = add_a_reg;
        add_s_next   = add_s_reg;
        add_m_next   = add_m_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        fcnt_next    = fcnt_reg;
        acnt_next    = acnt_reg;
        out_v_next   = out_v_reg && !rsp.ready;
        out_st_next  = out_st_reg;
        out_res_next = out_res_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;
        go_act       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next   = req.func;
                    ka_next     = W'(req.addr);
                    ks_next     = W'(req.size);
                    km_next     = (req.func == FN_ADD) ? req.merge : 1'b0;
                    phase_next  = PH_MAIN;
                    tsel_next   = (req.func == FN_FREE) ? TB_ALLOC : TB_FREE;
                    ri_next     = '0;
                    pv_next     = 1'b0;
                    wr_p_next   = 1'b0;
                    rm_p_next   = 1'b0;
                    ins_p_next  = 1'b0;
                    go_add_next = 1'b0;
                    st_next     = ST_OK;
                    res_next    = '0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                mem_raddr = ri_reg[AW-1:0];
                pv_next   = ri_reg < n_sel;
                rj_next   = ri_reg;
                if (ri_reg < n_sel)
                begin
                    ri_next = ri_reg + 1'b1;
                end
                if (pv_reg && !match)
                begin
                    prev_s_next = rs;
                    prev_l_next = rl;
                end
                if (hit || done_nf)
                begin
                    pv_next = 1'b0;
                    if (is_add)
                    begin
                        if (!r_jp && spare0)
                        begin
                            st_next    = ST_NODESC;
                            res_next   = '0;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            go_act = 1'b1;
                            if (r_jp)
                            begin
                                wr_p_next = 1'b1;
                                wr_i_next = AW'(pos - 1'b1);
                                wr_d_next = {prev_s_reg,
                                             W'(prev_l_reg + ks_reg + (r_m2 ? rl : '0))};
                                rm_p_next = r_m2;
                                rm_i_next = pos[AW-1:0];
                            end
                            else if (r_m2)
                            begin
                                wr_p_next = 1'b1;
                                wr_i_next = pos[AW-1:0];
                                wr_d_next = {ka_reg, W'(ks_reg + rl)};
                            end
                            else
                            begin
                                ins_p_next = 1'b1;
                                ins_i_next = pos[AW-1:0];
                                ins_d_next = {ka_reg, ks_reg};
                            end
                        end
                    end
                    else if (!hit)
                    begin
                        st_next    = (func_reg == FN_FREE) ? ST_NOTALLOC : ST_NOFIT;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        unique case (func_reg)
                            FN_FIT:
                            begin
                                if (r_split && spare0)
                                begin
                                    st_next    = ST_NODESC;
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    go_act      = 1'b1;
                                    wr_p_next   = r_split;
                                    wr_i_next   = rj_reg[AW-1:0];
                                    wr_d_next   = {W'(rs + ks_reg), W'(rl - ks_reg)};
                                    rm_p_next   = !r_split;
                                    rm_i_next   = rj_reg[AW-1:0];
                                    go_add_next = 1'b1;
                                    add_t_next  = TB_ALLOC;
                                    add_a_next  = rs;
                                    add_s_next  = ks_reg;
                                    add_m_next  = 1'b0;
                                    res_next    = rs;
                                end
                            end
                            FN_AT:
                            begin
                                if (need_bad)
                                begin
                                    st_next    = ST_NODESC;
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    go_act      = 1'b1;
                                    rm_i_next   = rj_reg[AW-1:0];
                                    wr_i_next   = rj_reg[AW-1:0];
                                    ins_i_next  = AW'(rj_reg + 1'b1);
                                    ins_d_next  = {kend, W'(rend - kend)};
                                    go_add_next = 1'b1;
                                    add_t_next  = TB_ALLOC;
                                    add_a_next  = ka_reg;
                                    add_s_next  = ks_reg;
                                    add_m_next  = 1'b0;
                                    res_next    = ka_reg;
                                    if (k0)
                                    begin
                                        rm_p_next = 1'b1;
                                    end
                                    else if (k1)
                                    begin
                                        wr_p_next = 1'b1;
                                        wr_d_next = {kend, W'(rl - ks_reg)};
                                    end
                                    else if (k2)
                                    begin
                                        wr_p_next = 1'b1;
                                        wr_d_next = {rs, W'(rl - ks_reg)};
                                    end
                                    else
                                    begin
                                        // Split: keep the front, add the tail after it.
                                        wr_p_next  = 1'b1;
                                        wr_d_next  = {rs, W'(ka_reg - rs)};
                                        ins_p_next = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                go_act      = 1'b1;
                                rm_p_next   = 1'b1;
                                rm_i_next   = rj_reg[AW-1:0];
                                go_add_next = 1'b1;
                                add_t_next  = TB_FREE;
                                add_a_next  = ka_reg;
                                add_s_next  = rl;
                                add_m_next  = 1'b1;
                            end
                        endcase
                    end
                end
            end

            S_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_i_reg;
                mem_wdata = wr_d_reg;
                wr_p_next = 1'b0;
                go_act    = 1'b1;
            end

            S_RM:
            begin
                // Shift entries above the removed one down by one place.
                mem_raddr = ri_reg[AW-1:0];
                pv_next   = ri_reg < n_sel;
                rj_next   = ri_reg;
                if (ri_reg < n_sel)
                begin
                    ri_next = ri_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(rj_reg - 1'b1);
                    mem_wdata = rd;
                end
                else if (ri_reg >= n_sel)
                begin
                    pv_next   = 1'b0;
                    rm_p_next = 1'b0;
                    go_act    = 1'b1;
                    if (tsel_reg == TB_ALLOC)
                    begin
                        acnt_next = acnt_reg - 1'b1;
                    end
                    else
                    begin
                        fcnt_next = fcnt_reg - 1'b1;
                    end
                end
            end

            S_INS:
            begin
                // Shift entries up by one place, from the top down, then write the hole.
                mem_raddr = AW'(ri_reg - 1'b1);
                pv_next   = ri_reg > CW'(ins_i_reg);
                rj_next   = ri_reg;
                if (ri_reg > CW'(ins_i_reg))
                begin
                    ri_next = ri_reg - 1'b1;
                end
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rj_reg[AW-1:0];
                    mem_wdata = rd;
                end
                else if (ri_reg <= CW'(ins_i_reg))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ins_i_reg;
                    mem_wdata  = ins_d_reg;
                    pv_next    = 1'b0;
                    ins_p_next = 1'b0;
                    go_act     = 1'b1;
                    if (tsel_reg == TB_ALLOC)
                    begin
                        acnt_next = acnt_reg + 1'b1;
                    end
                    else
                    begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                end
            end

            S_POST:
            begin
                if (go_add_reg)
                begin
                    phase_next  = PH_ADD;
                    tsel_next   = add_t_reg;
                    ka_next     = add_a_reg;
                    ks_next     = add_s_reg;
                    km_next     = add_m_reg;
                    go_add_next = 1'b0;
                    ri_next     = '0;
                    pv_next     = 1'b0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_v_reg || rsp.ready)
                begin
                    out_v_next   = 1'b1;
                    out_st_next  = st_reg;
                    out_res_next = (st_reg == ST_OK) ? res_reg : '0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Run the pending table actions in order: write, remove, insert.
        if (go_act)
        begin
            pv_next = 1'b0;
            if (wr_p_next)
            begin
                state_next = S_WR;
            end
            else if (rm_p_next)
            begin
                ri_next    = CW'(rm_i_next) + 1'b1;
                state_next = S_RM;
            end
            else if (ins_p_next)
            begin
                ri_next    = (tsel_reg == TB_ALLOC) ? acnt_next : fcnt_next;
                state_next = S_INS;
            end
            else
            begin
                state_next = S_POST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_MAIN;
            pv_reg     <= 1'b0;
            wr_p_reg   <= 1'b0;
            rm_p_reg   <= 1'b0;
            ins_p_reg  <= 1'b0;
            go_add_reg <= 1'b0;
            fcnt_reg   <= '0;
            acnt_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pv_reg     <= pv_next;
            wr_p_reg   <= wr_p_next;
            rm_p_reg   <= rm_p_next;
            ins_p_reg  <= ins_p_next;
            go_add_reg <= go_add_next;
            fcnt_reg   <= fcnt_next;
            acnt_reg   <= acnt_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        tsel_reg    <= tsel_next;
        ka_reg      <= ka_next;
        ks_reg      <= ks_next;
        km_reg      <= km_next;
        ri_reg      <= ri_next;
        rj_reg      <= rj_next;
        prev_s_reg  <= prev_s_next;
        prev_l_reg  <= prev_l_next;
        wr_i_reg    <= wr_i_next;
        wr_d_reg    <= wr_d_next;
        rm_i_reg    <= rm_i_next;
        ins_i_reg   <= ins_i_next;
        ins_d_reg   <= ins_d_next;
        add_t_reg   <= add_t_next;
        add_a_reg   <= add_a_next;
        add_s_reg   <= add_s_next;
        add_m_reg   <= add_m_next;
        st_reg      <= st_next;
        res_reg     <= res_next;
        out_st_reg  <= out_st_next;
        out_res_reg <= out_res_next;
    end

    assign req.ready       = state_reg == S_IDLE;
    assign rsp.valid       = out_v_reg;
    assign rsp.status      = out_st_reg;
    assign rsp.result_addr = DATA_W'(out_res_reg);

endmodule

// ----- hw/rtl/ffea_checker.sv -----
// Port-level checks for the first-fit extent allocator, bound to the top level.
// Depends on ffea_pkg and on first_fit_extent_allocator.
module ffea_checker
    import ffea_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] result_addr,
    input logic [STAT_W-1:0] status
);

    // A stalled result beat holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_addr) && $stable(status))
        else $error("result beat changed while stalled");

    // A failed operation never reports an address.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> result_addr == '0)
        else $error("failed operation carries an address");

    // The block works on one request at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A result only appears after the block has been busy.
    a_rsp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_ready) == 1'b0)
        else $error("result appeared without work");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .result_addr (rsp.result_addr),
    .status      (rsp.status)
);

// ----- test/first_fit_extent_allocator_tb.sv -----
// Self-checking testbench for the first-fit extent allocator.
// Drives request beats through a table of directed cases and then random traffic,
// and checks every result beat against its written outcome or a model of both extent tables.
// Depends on ffea_pkg, ffea_if.sv and first_fit_extent_allocator.sv.
module first_fit_extent_allocator_tb;
    import ffea_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int N_RANDOM  = 450;
    localparam int CALM_TAIL = 80;   // the last random beats run without idling

    typedef struct {
        logic [DATA_W-1:0] result_addr;
        logic [STAT_W-1:0] status;
    } outcome_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] size;
        logic              merge;
        bit                typed;       // when set, the outcome below is checked as written
        logic [DATA_W-1:0] exp_addr;
        logic [STAT_W-1:0] exp_status;
    } case_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ffea_req_if req_ch();
    ffea_rsp_if rsp_ch();

    first_fit_extent_allocator #(.ENTRIES(ENTRIES), .ADDR_W(DATA_W)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // Our own copy of the two extent tables. Index TB_FREE holds the free
    // extents and TB_ALLOC the allocated ones; both share one descriptor pool.
    logic [DATA_W-1:0] ext_start [2][ENTRIES];
    logic [DATA_W-1:0] ext_len   [2][ENTRIES];
    int                ext_cnt   [2];

    outcome_t pending_outcomes[$];
    int       fails      = 0;
    int       sent_beats = 0;
    bit       calm       = 1'b0;  // no idling on either side once set

    function automatic int spare_descriptors();
        int used;
        used = ext_cnt[TB_FREE] + ext_cnt[TB_ALLOC];
        return (used >= ENTRIES) ? 0 : ENTRIES - used;
    endfunction

    function automatic void table_insert(logic t, int pos, logic [DATA_W-1:0] s,
                                         logic [DATA_W-1:0] l);
        if (ext_cnt[t] >= ENTRIES || pos > ext_cnt[t])
            return;
        for (int i = ext_cnt[t]; i > pos; i--)
        begin
            ext_start[t][i] = ext_start[t][i-1];
            ext_len[t][i]   = ext_len[t][i-1];
        end
        ext_start[t][pos] = s;
        ext_len[t][pos]   = l;
        ext_cnt[t]++;
    endfunction

    function automatic void table_remove(logic t, int pos);
        if (pos >= ext_cnt[t])
            return;
        for (int i = pos; i + 1 < ext_cnt[t]; i++)
        begin
            ext_start[t][i] = ext_start[t][i+1];
            ext_len[t][i]   = ext_len[t][i+1];
        end
        ext_cnt[t]--;
    endfunction

    // Sorted insert of a region, optionally joining the neighbour that ends at
    // its start and the one that begins at its end. Sums wrap at 32 bits.
    function automatic logic [STAT_W-1:0] insert_region(logic t, logic [DATA_W-1:0] a,
                                                        logic [DATA_W-1:0] sz, logic mrg);
        int  pos;
        int  e;
        int  nxt;
        bit  join_prev;
        logic [DATA_W-1:0] prev_end;
        pos = 0;
        while (pos < ext_cnt[t] && !(a < ext_start[t][pos]))
            pos++;
        join_prev = 1'b0;
        if (mrg && pos > 0)
        begin
            prev_end  = ext_start[t][pos-1] + ext_len[t][pos-1];
            join_prev = (prev_end == a);
        end
        if (!join_prev && spare_descriptors() == 0)
            return ST_NODESC;
        if (join_prev)
        begin
            e = pos - 1;
            ext_len[t][e] = ext_len[t][e] + sz;
            nxt = pos;
        end
        else
        begin
            table_insert(t, pos, a, sz);
            e = pos;
            nxt = pos + 1;
        end
        if (mrg && nxt < ext_cnt[t] && DATA_W'(a + sz) == ext_start[t][nxt])
        begin
            ext_len[t][e] = ext_len[t][e] + ext_len[t][nxt];
            table_remove(t, nxt);
        end
        return ST_OK;
    endfunction

    // Works out the result beat of one request and updates the tables.
    function automatic outcome_t allocator_outcome(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] sz, logic mrg);
        outcome_t o;
        int i;
        int need;
        logic [DATA_W-1:0] fs;
        logic [DATA_W-1:0] fl;
        logic [DATA_W-1:0] fend;
        logic [DATA_W-1:0] end_spec;
        logic [DATA_W-1:0] l;
        o.result_addr = '0;
        o.status      = ST_OK;
        case (fn)
            FN_ADD:
                o.status = insert_region(TB_FREE, a, sz, mrg);
            FN_FIT:
            begin
                i = 0;
                while (i < ext_cnt[TB_FREE] && !(ext_len[TB_FREE][i] >= sz))
                    i++;
                if (i >= ext_cnt[TB_FREE])
                    o.status = ST_NOFIT;
                else if (sz < ext_len[TB_FREE][i] && spare_descriptors() < 1)
                    o.status = ST_NODESC;
                else
                begin
                    fs = ext_start[TB_FREE][i];
                    if (sz < ext_len[TB_FREE][i])
                    begin
                        ext_start[TB_FREE][i] = ext_start[TB_FREE][i] + sz;
                        ext_len[TB_FREE][i]   = ext_len[TB_FREE][i] - sz;
                    end
                    else
                        table_remove(TB_FREE, i);
                    o.status      = insert_region(TB_ALLOC, fs, sz, 1'b0);
                    o.result_addr = fs;
                end
            end
            FN_AT:
            begin
                end_spec = a + sz;
                i = 0;
                while (i < ext_cnt[TB_FREE] && !(ext_start[TB_FREE][i] <= a &&
                       end_spec <= DATA_W'(ext_start[TB_FREE][i] + ext_len[TB_FREE][i])))
                    i++;
                if (i >= ext_cnt[TB_FREE])
                    o.status = ST_NOFIT;
                else
                begin
                    fs   = ext_start[TB_FREE][i];
                    fl   = ext_len[TB_FREE][i];
                    fend = fs + fl;
                    // An exact fit needs no descriptor, a trim needs one, a split two.
                    if (fl == sz)
                        need = 0;
                    else if (fs == a || fend == end_spec)
                        need = 1;
                    else
                        need = 2;
                    if (spare_descriptors() < need)
                        o.status = ST_NODESC;
                    else
                    begin
                        if (fl == sz)
                            table_remove(TB_FREE, i);
                        else if (fs == a)
                        begin
                            ext_start[TB_FREE][i] = end_spec;
                            ext_len[TB_FREE][i]   = fl - sz;
                        end
                        else if (fend == end_spec)
                            ext_len[TB_FREE][i] = fl - sz;
                        else
                        begin
                            ext_len[TB_FREE][i] = a - fs;
                            table_insert(TB_FREE, i + 1, end_spec, fend - end_spec);
                        end
                        o.status      = insert_region(TB_ALLOC, a, sz, 1'b0);
                        o.result_addr = a;
                    end
                end
            end
            default:
            begin
                i = 0;
                while (i < ext_cnt[TB_ALLOC] && ext_start[TB_ALLOC][i] != a)
                    i++;
                if (i >= ext_cnt[TB_ALLOC])
                    o.status = ST_NOTALLOC;
                else
                begin
                    l = ext_len[TB_ALLOC][i];
                    table_remove(TB_ALLOC, i);
                    o.status = insert_region(TB_FREE, a, l, 1'b1);
                end
            end
        endcase
        if (o.status != ST_OK)
            o.result_addr = '0;
        return o;
    endfunction

    // Directed cases. Rows whose outcome is plain from the operation alone carry
    // it; the rest (splits, trims, wrapped sizes) are left to the model.
    case_t directed [] = '{
        '{FN_FIT,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 32'h0, ST_NOFIT},
        '{FN_FREE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1, 32'h0, ST_NOTALLOC},
        '{FN_AT,   32'h0000_0000, 32'h0000_0000, 1'b1, 1, 32'h0, ST_NOFIT},
        '{FN_ADD,  32'h0000_1000, 32'h0000_1000, 1'b0, 1, 32'h0, ST_OK},
        '{FN_ADD,  32'h0000_2000, 32'h0000_1000, 1'b1, 1, 32'h0, ST_OK},
        '{FN_FIT,  32'h0000_0000, 32'h0000_0010, 1'b0, 1, 32'h1000, ST_OK},
        '{FN_AT,   32'h0000_1800, 32'h0000_0100, 1'b0, 0, 32'h0, ST_OK},
        '{FN_AT,   32'h0000_1010, 32'h0000_0010, 1'b0, 0, 32'h0, ST_OK},
        '{FN_FIT,  32'h0000_0000, 32'h0000_0000, 1'b0, 0, 32'h0, ST_OK},
        '{FN_FREE, 32'h0000_1000, 32'h0000_0000, 1'b0, 1, 32'h0, ST_OK},
        '{FN_FREE, 32'h0000_1234, 32'h0000_0000, 1'b0, 1, 32'h0, ST_NOTALLOC},
        '{FN_AT,   32'h0000_2F00, 32'h0000_0100, 1'b0, 0, 32'h0, ST_OK},
        '{FN_ADD,  32'hFFFF_FFF0, 32'h0000_0020, 1'b1, 1, 32'h0, ST_OK},
        '{FN_FIT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1, 32'h0, ST_NOFIT},
        '{FN_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1, 32'h0, ST_OK},
        '{FN_FIT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 32'h0, ST_OK},
        '{FN_ADD,  32'h0000_5000, 32'h0000_0000, 1'b0, 1, 32'h0, ST_OK},
        '{FN_FIT,  32'h0000_0000, 32'h0000_0000, 1'b0, 0, 32'h0, ST_OK},
        '{FN_FREE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0, 32'h0, ST_OK},
        '{FN_AT,   32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 0, 32'h0, ST_OK}
    };

    // Offers one request beat and waits for it to be taken. The model runs at
    // the accepting edge, so its expectation is queued before any result can
    // appear. A gap, when one is drawn, lowers valid beforehand.
    task automatic offer_request(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] a,
                                 logic [DATA_W-1:0] sz, logic mrg, bit typed,
                                 outcome_t typed_outcome);
        outcome_t o;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= fn;
        req_ch.addr  <= a;
        req_ch.size  <= sz;
        req_ch.merge <= mrg;
        do
            @(posedge clk);
        while (!req_ch.ready);
        o = allocator_outcome(fn, a, sz, mrg);
        pending_outcomes.push_back(typed ? typed_outcome : o);
        sent_beats++;
    endtask

    // Random requests, mostly inside a small address window so that extents
    // meet, split and merge; the rest are full-width noise.
    task automatic random_request(int add_weight);
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] sz;
        logic [63:0]       off;
        logic [63:0]       room;
        int                i;
        outcome_t          unused;
        unused = '{'0, ST_OK};
        fn = ($urandom_range(0, 99) < add_weight) ? FN_ADD : FUNC_W'($urandom_range(1, 3));
        a  = DATA_W'($urandom_range(0, 'h3FF)) << 4;
        sz = DATA_W'($urandom_range(0, 'h200));
        if (fn == FN_AT && ext_cnt[TB_FREE] > 0 && $urandom_range(0, 4) != 0)
        begin
            // Carve from a live free extent: exact fits, trims and splits.
            i    = $urandom_range(0, ext_cnt[TB_FREE] - 1);
            off  = (ext_len[TB_FREE][i] == 0) ? 64'd0 : 64'($urandom % ext_len[TB_FREE][i]);
            if ($urandom_range(0, 3) == 0)
                off = 64'd0;
            room = 64'(ext_len[TB_FREE][i]) - off + 64'd1;
            a  = ext_start[TB_FREE][i] + DATA_W'(off);
            sz = ($urandom_range(0, 3) == 0) ? DATA_W'(room - 1) : DATA_W'($urandom % room);
        end
        else if (fn == FN_FREE && ext_cnt[TB_ALLOC] > 0 && $urandom_range(0, 4) != 0)
            a = ext_start[TB_ALLOC][$urandom_range(0, ext_cnt[TB_ALLOC] - 1)];
        if ($urandom_range(0, 9) == 0)
        begin
            a  = $urandom;
            sz = $urandom;
        end
        offer_request(fn, a, sz, 1'($urandom_range(0, 1)), 1'b0, unused);
    endtask

    // Result checking: every accepted result beat is matched to the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat with no request waiting: result_addr %h status %0d",
                       rsp_ch.result_addr, rsp_ch.status);
                fails++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.result_addr !== want.result_addr)
                begin
                    $error("result_addr: expected %h, got %h",
                           want.result_addr, rsp_ch.result_addr);
                    fails++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fails++;
                end
            end
        end
    end

    // Result side. Stalls come in random bursts, and once, part way through
    // the random traffic, a long hold-off lets the block fill up so that it
    // must stall its request channel.
    initial
    begin
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (!held && sent_beats >= 200)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Overall limit on the run, far beyond the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus and the end of the run.
    initial
    begin
        outcome_t typed_outcome;
        ext_cnt[TB_FREE]  = 0;
        ext_cnt[TB_ALLOC] = 0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FN_ADD;
        req_ch.addr  <= '0;
        req_ch.size  <= '0;
        req_ch.merge <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            typed_outcome = '{directed[k].exp_addr, directed[k].exp_status};
            offer_request(directed[k].func, directed[k].addr, directed[k].size,
                          directed[k].merge, directed[k].typed, typed_outcome);
        end

        // Three moods of traffic: add-heavy to use up the descriptor pool,
        // balanced, then allocation-heavy to drain the free table.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n >= N_RANDOM - CALM_TAIL)
                calm = 1'b1;
            random_request((n < 150) ? 55 : (n < 300) ? 30 : 15);
        end
        req_ch.valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fails == 0 && pending_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
